// ===== src/glp_pkg.sv =====
package glp_pkg;

  localparam int DATA_W = 32;
  localparam int RES_W  = 64;

  localparam logic [1:0] OP_GCD   = 2'd0;
  localparam logic [1:0] OP_LCM   = 2'd1;
  localparam logic [1:0] OP_PRIME = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_GCD   = 6'b000010,
    ST_LDIV  = 6'b000100,
    ST_LMUL  = 6'b001000,
    ST_PCHK  = 6'b010000,
    ST_PDIV  = 6'b100000
  } state_t;

endpackage

// ===== src/glp_div.sv =====
module glp_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem_r, quo_r[W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(W);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (run_r) begin
      // partial remainder stays below twice the divisor, so diff[W] is the borrow
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
      end else begin
        rem_nxt = rem_sh[W-1:0];
      end
      quo_nxt = {quo_r[W-2:0], ~diff[W]};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== src/gcd_lcm_prime_unit.sv =====
// gcd runs k Euclid remainder steps on the divider; lcm then divides max/gcd on the
// divider and multiplies the quotient by the min; primality trial-divides by d = 2, 3, ...
// while d*d <= n. Trivial cases (operand a zero, n below 4, unused opcode) answer in the
// cycle after start. One item at a time; busy stays high until the result strobe; all
// divisions use one shared radix-2 divider (W = OPERAND_WIDTH).
// Synchronous active-low reset returns the sequencer to idle; the receiver cannot stall.
module gcd_lcm_prime_unit
  import glp_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [DATA_W-1:0] in_operand_a,
  input  logic [DATA_W-1:0] in_operand_b,
  output logic              out_valid,
  output logic [RES_W-1:0]  out_result_value,
  output logic              out_undefined_flag
);

  localparam int W   = OPERAND_WIDTH;
  localparam int SQW = 2 * W;

  state_t         state_r, state_nxt;
  logic [1:0]     op_r, op_nxt;
  logic [W-1:0]   a_r, a_nxt;
  logic [W-1:0]   b_r, b_nxt;
  logic [W-1:0]   x_r, x_nxt;
  logic [W-1:0]   q_r, q_nxt;
  logic [W-1:0]   d_r, d_nxt;
  logic [SQW-1:0] sq_r, sq_nxt;
  logic           ov_r, ov_nxt;
  logic [RES_W-1:0] res_r, res_nxt;
  logic           flag_r, flag_nxt;

  logic [W-1:0]   a_in, b_in;
  logic [W-1:0]   hi, lo;
  logic [SQW-1:0] prod;
  logic           div_start;
  logic [W-1:0]   div_dividend, div_divisor;
  logic           div_done;
  logic [W-1:0]   div_quo, div_rem;

  glp_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign a_in = in_operand_a[W-1:0];
  assign b_in = in_operand_b[W-1:0];
  assign hi   = (a_r > b_r) ? a_r : b_r;
  assign lo   = (a_r > b_r) ? b_r : a_r;
  assign prod = SQW'(q_r) * SQW'(lo);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    x_nxt        = x_r;
    q_nxt        = q_r;
    d_nxt        = d_r;
    sq_nxt       = sq_r;
    ov_nxt       = 1'b0;
    res_nxt      = res_r;
    flag_nxt     = flag_r;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt   = in_opcode;
          a_nxt    = a_in;
          b_nxt    = b_in;
          x_nxt    = a_in;
          flag_nxt = 1'b0;
          if (in_opcode == OP_GCD || in_opcode == OP_LCM) begin
            if (in_opcode == OP_LCM && a_in == '0 && b_in == '0) begin
              ov_nxt   = 1'b1;
              res_nxt  = '0;
              flag_nxt = 1'b1;
            end else if (a_in == '0) begin
              // gcd(0,b) = b; lcm with a zero operand is zero
              ov_nxt  = 1'b1;
              res_nxt = (in_opcode == OP_GCD) ? RES_W'(b_in) : '0;
            end else begin
              div_start    = 1'b1;
              div_dividend = b_in;
              div_divisor  = a_in;
              state_nxt    = ST_GCD;
            end
          end else if (in_opcode == OP_PRIME) begin
            if (a_in[W-1:1] == '0) begin
              ov_nxt  = 1'b1;
              res_nxt = '0;
            end else if (a_in == W'(2) || a_in == W'(3)) begin
              ov_nxt  = 1'b1;
              res_nxt = RES_W'(1);
            end else begin
              d_nxt     = W'(2);
              sq_nxt    = SQW'(4);
              state_nxt = ST_PCHK;
            end
          end else begin
            ov_nxt  = 1'b1;
            res_nxt = '0;
          end
        end
      end
      ST_GCD: begin
        if (div_done) begin
          if (div_rem == '0) begin
            // x_r holds the gcd
            if (op_r == OP_GCD) begin
              ov_nxt    = 1'b1;
              res_nxt   = RES_W'(x_r);
              state_nxt = ST_IDLE;
            end else begin
              div_start    = 1'b1;
              div_dividend = hi;
              div_divisor  = x_r;
              state_nxt    = ST_LDIV;
            end
          end else begin
            x_nxt        = div_rem;
            div_start    = 1'b1;
            div_dividend = x_r;
            div_divisor  = div_rem;
          end
        end
      end
      ST_LDIV: begin
        if (div_done) begin
          q_nxt     = div_quo;
          state_nxt = ST_LMUL;
        end
      end
      ST_LMUL: begin
        ov_nxt    = 1'b1;
        res_nxt   = RES_W'(prod);
        state_nxt = ST_IDLE;
      end
      ST_PCHK: begin
        if (sq_r > SQW'(a_r)) begin
          ov_nxt    = 1'b1;
          res_nxt   = RES_W'(1);
          state_nxt = ST_IDLE;
        end else begin
          div_start    = 1'b1;
          div_dividend = a_r;
          div_divisor  = d_r;
          state_nxt    = ST_PDIV;
        end
      end
      ST_PDIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            ov_nxt    = 1'b1;
            res_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + SQW'({d_r, 1'b1});
            d_nxt     = d_r + W'(1);
            state_nxt = ST_PCHK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    x_r    <= x_nxt;
    q_r    <= q_nxt;
    d_r    <= d_nxt;
    sq_r   <= sq_nxt;
    res_r  <= res_nxt;
    flag_r <= flag_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = ov_r;
  assign out_result_value   = res_r;
  assign out_undefined_flag = flag_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted item neither started nor answered");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_undefined_flag |-> out_result_value == '0)
    else $error("undefined lcm with nonzero value");

  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> busy)
    else $error("divider finished while idle");

endmodule

// ===== tb/glp_checker.sv =====
`timescale 1ns / 1ps

module glp_checker
  import glp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [DATA_W-1:0] in_operand_a,
  input  logic [DATA_W-1:0] in_operand_b,
  input  logic              out_valid,
  input  logic [RES_W-1:0]  out_result_value,
  input  logic              out_undefined_flag,
  output int                mismatches,
  output int                pending
);

  localparam int OPW = 32;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [RES_W-1:0] value;
    logic             undef;
  } glp_result_t;

  glp_result_t expected_q[$];

  function automatic logic [RES_W-1:0] euclid_gcd(input logic [RES_W-1:0] x,
                                                  input logic [RES_W-1:0] y);
    logic [RES_W-1:0] r;
    while (x != 0) begin
      r = y % x;
      y = x;
      x = r;
    end
    return y;
  endfunction

  function automatic bit is_prime_num(input logic [RES_W-1:0] n);
    logic [RES_W-1:0] d;
    if (n < 2) return 1'b0;
    if (n == 2 || n == 3) return 1'b1;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic glp_result_t predict_result(input logic [1:0]        op,
                                                 input logic [DATA_W-1:0] a_in,
                                                 input logic [DATA_W-1:0] b_in);
    glp_result_t res;
    logic [RES_W-1:0] mask;
    logic [RES_W-1:0] a;
    logic [RES_W-1:0] b;
    logic [RES_W-1:0] hi;
    logic [RES_W-1:0] lo;
    mask = (64'd1 << OPW) - 64'd1;
    a = {32'd0, a_in} & mask;
    b = {32'd0, b_in} & mask;
    res.value = '0;
    res.undef = 1'b0;
    case (op)
      OP_GCD: res.value = euclid_gcd(a, b);
      OP_LCM: begin
        if (a == 0 && b == 0) begin
          res.undef = 1'b1;
        end else begin
          hi = (a > b) ? a : b;
          lo = (a > b) ? b : a;
          res.value = (hi / euclid_gcd(a, b)) * lo;
        end
      end
      OP_PRIME: res.value = is_prime_num(a) ? 64'd1 : 64'd0;
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    glp_result_t exp_r;
    if (!rst_n) begin
      expected_q.delete();
      mismatches = 0;
      pending = 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: result with no item outstanding: value=%h undef=%b",
                     $realtime, out_result_value, out_undefined_flag);
          mismatches++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_result_value !== exp_r.value || out_undefined_flag !== exp_r.undef) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: exp value=%h undef=%b, got value=%h undef=%b",
                       $realtime, exp_r.value, exp_r.undef,
                       out_result_value, out_undefined_flag);
            mismatches++;
          end
        end
      end
      if (start && !busy)
        expected_q.insert(expected_q.size(),
                          predict_result(in_opcode, in_operand_a, in_operand_b));
      pending = expected_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import glp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_RANDOM = 1280;
  localparam int QUIET_TAIL = 180;  // last items go back to back
  localparam int WATCHDOG = 300000;
  localparam logic [31:0] MAXV = 32'hFFFF_FFFF;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_opcode;
  logic [DATA_W-1:0] in_operand_a;
  logic [DATA_W-1:0] in_operand_b;
  logic              out_valid;
  logic [RES_W-1:0]  out_result_value;
  logic              out_undefined_flag;
  int                mismatches;
  int                pending;
  int                idle_cycles;

  gcd_lcm_prime_unit #(.OPERAND_WIDTH(32)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .out_valid         (out_valid),
    .out_result_value  (out_result_value),
    .out_undefined_flag(out_undefined_flag)
  );

  glp_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .out_valid         (out_valid),
    .out_result_value  (out_result_value),
    .out_undefined_flag(out_undefined_flag),
    .mismatches        (mismatches),
    .pending           (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic send_item(input logic [1:0] op, input logic [31:0] a,
                           input logic [31:0] b, input bit allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start        <= 1'b1;
    in_opcode    <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return MAXV;
      2, 3:    return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Trial division is slow, so primality items stay small except for large
  // numbers with a tiny factor.
  function automatic logic [31:0] pick_prime_candidate();
    case ($urandom_range(0, 19))
      0:       return $urandom & ~32'd1;
      1:       return ($urandom % 32'd1431655765) * 32'd3;
      2, 3:    return $urandom_range(0, 65535);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] g;
    int          sel;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_opcode    <= OP_GCD;
    in_operand_a <= '0;
    in_operand_b <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zeros, extremes, long Euclid chain, prime edge values
    send_item(OP_GCD,    32'd0,          32'd0,          1'b1);
    send_item(OP_GCD,    32'd0,          32'd77,         1'b1);
    send_item(OP_GCD,    32'd91,         32'd0,          1'b1);
    send_item(OP_GCD,    MAXV,           MAXV,           1'b1);
    send_item(OP_GCD,    MAXV,           MAXV - 1,       1'b1);
    send_item(OP_GCD,    32'd1836311903, 32'd1134903170, 1'b1);
    send_item(OP_GCD,    32'd12,         32'd18,         1'b0);
    send_item(OP_LCM,    32'd0,          32'd0,          1'b1);
    send_item(OP_LCM,    32'd0,          32'd5,          1'b1);
    send_item(OP_LCM,    32'd7,          32'd0,          1'b1);
    send_item(OP_LCM,    MAXV,           MAXV - 1,       1'b1);
    send_item(OP_LCM,    MAXV,           MAXV,           1'b1);
    send_item(OP_LCM,    32'd4,          32'd6,          1'b0);
    send_item(OP_PRIME,  32'd0,          MAXV,           1'b1);
    send_item(OP_PRIME,  32'd1,          32'd0,          1'b1);
    send_item(OP_PRIME,  32'd2,          MAXV,           1'b1);
    send_item(OP_PRIME,  32'd3,          32'd0,          1'b1);
    send_item(OP_PRIME,  32'd4,          32'd0,          1'b1);
    send_item(OP_PRIME,  32'd25,         32'd0,          1'b1);
    send_item(OP_PRIME,  32'd63001,      32'd0,          1'b1);   // 251 squared
    send_item(OP_PRIME,  32'd1048573,    MAXV,           1'b1);
    send_item(OP_PRIME,  MAXV,           MAXV,           1'b1);
    send_item(OP_PRIME,  MAXV - 1,       32'd0,          1'b0);
    send_item(OP_UNUSED, MAXV,           MAXV,           1'b1);
    send_item(OP_UNUSED, 32'd0,          32'd0,          1'b1);

    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) op = OP_GCD;
      else if (sel < 70) op = OP_LCM;
      else if (sel < 95) op = OP_PRIME;
      else op = OP_UNUSED;
      if (op == OP_PRIME) begin
        a = pick_prime_candidate();
        b = $urandom;
      end else if ($urandom_range(0, 3) == 0) begin
        // shared factor so the gcd is not trivially 1
        g = $urandom_range(1, 65535);
        a = g * $urandom_range(0, 65535);
        b = g * $urandom_range(0, 65535);
      end else begin
        a = pick_operand();
        b = pick_operand();
      end
      send_item(op, a, b, i < N_RANDOM - QUIET_TAIL);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/glp_pkg.sv
src/glp_div.sv
src/gcd_lcm_prime_unit.sv
tb/glp_checker.sv
tb/tb.sv
